/* hdl/lzss_window_decompressor_defines.svh */
// Assertion macros used by the bound checker file.
`ifndef LZSS_WINDOW_DECOMPRESSOR_DEFINES_SVH
`define LZSS_WINDOW_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LZSSWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LZSSWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lzsswd_pkg.sv */
`default_nettype none
package lzsswd_pkg;

  // Window geometry
  localparam int WIN_DEPTH        = 128;
  localparam int LOOKAHEAD        = 16;
  localparam int MIN_MATCH_OFFSET = 2;
  localparam int WIN_AW           = $clog2(WIN_DEPTH);
  localparam int FILL_LIMIT       = WIN_DEPTH - LOOKAHEAD;
  localparam logic [WIN_AW-1:0] WP_START = WIN_AW'(FILL_LIMIT);

  // Byte used to prefill the low part of the window
  localparam logic [7:0] FILL_BYTE = 8'h20;

  // Run counter holds the count minus one: low nibble + MIN_MATCH_OFFSET
  localparam int RUN_W = 5;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_start;
  } src_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } dst_word_t;

  // Window port request from the sequencer
  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [WIN_AW-1:0] raddr;
    logic              clr_low;
  } win_req_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LIT   = 4'b0010,
    ST_READ  = 4'b0100,
    ST_WRITE = 4'b1000
  } seq_state_t;

endpackage
`default_nettype wire

/* hdl/lzsswd_window.sv */
`default_nettype none
module lzsswd_window (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lzsswd_pkg::win_req_t req,
  output logic [7:0]            rdata
);
  import lzsswd_pkg::*;

  logic [7:0]           mem [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] vld;
  logic [7:0]           mem_q;
  logic                 rd_vld;
  logic                 rd_low;

  // Valid bits: cleared by reset, low part cleared on a new stream
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        if (req.clr_low && (i < FILL_LIMIT)) begin
          vld[i] <= 1'b0;
        end
      end
      if (req.we) begin
        vld[req.waddr] <= 1'b1;
      end
    end
  end

  // Storage array, one write and one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      mem_q  <= mem[req.raddr];
      rd_vld <= vld[req.raddr];
      rd_low <= (req.raddr < WIN_AW'(FILL_LIMIT));
    end
  end

  // Unwritten low entries read as the fill value, unwritten upper entries as zero
  assign rdata = rd_vld ? mem_q : (rd_low ? FILL_BYTE : 8'h00);

endmodule
`default_nettype wire

/* hdl/lzsswd_ctrl.sv */
`default_nettype none
module lzsswd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  src_valid,
  output logic                       src_ready,
  input  wire lzsswd_pkg::src_word_t src_word,
  input  wire logic                  slot_free,
  output logic                       emit_valid,
  output lzsswd_pkg::dst_word_t      emit_word,
  output lzsswd_pkg::win_req_t       win_req,
  input  wire logic [7:0]            win_rdata
);
  import lzsswd_pkg::*;

  seq_state_t        state, state_next;
  logic [8:0]        flag, flag_next;
  logic              pending, pending_next;
  logic [7:0]        held, held_next;
  logic [WIN_AW-1:0] wp, wp_next;
  logic [WIN_AW-1:0] raddr, raddr_next;
  logic [RUN_W-1:0]  rem, rem_next;
  logic [7:0]        lit, lit_next;
  logic [11:0]       pos_full;

  assign src_ready = (state == ST_IDLE);
  assign pos_full  = {src_word.code_byte[7:4], held};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      flag    <= '0;
      pending <= 1'b0;
      held    <= '0;
      wp      <= WP_START;
    end else begin
      state   <= state_next;
      flag    <= flag_next;
      pending <= pending_next;
      held    <= held_next;
      wp      <= wp_next;
    end
  end

  always_ff @(posedge clk) begin
    raddr <= raddr_next;
    rem   <= rem_next;
    lit   <= lit_next;
  end

  // Sequencer: decode one word, then emit a literal or run the copy loop through the window port
  always_comb begin
    state_next   = state;
    flag_next    = flag;
    pending_next = pending;
    held_next    = held;
    wp_next      = wp;
    raddr_next   = raddr;
    rem_next     = rem;
    lit_next     = lit;
    win_req      = '0;
    emit_valid   = 1'b0;
    emit_word    = '0;

    unique case (state)
      ST_IDLE: begin
        if (src_valid) begin
          if (src_word.stream_start) begin
            // new stream: this word is always a flag word
            flag_next       = {1'b1, src_word.code_byte};
            pending_next    = 1'b0;
            held_next       = '0;
            wp_next         = WP_START;
            win_req.clr_low = 1'b1;
          end else if (flag[8:1] == '0) begin
            flag_next = {1'b1, src_word.code_byte};
          end else if (pending) begin
            raddr_next   = pos_full[WIN_AW-1:0];
            rem_next     = {1'b0, src_word.code_byte[3:0]} + RUN_W'(MIN_MATCH_OFFSET);
            pending_next = 1'b0;
            held_next    = '0;
            flag_next    = flag >> 1;
            state_next   = ST_READ;
          end else if (flag[0]) begin
            lit_next   = src_word.code_byte;
            flag_next  = flag >> 1;
            state_next = ST_LIT;
          end else begin
            held_next    = src_word.code_byte;
            pending_next = 1'b1;
          end
        end
      end

      ST_LIT: begin
        if (slot_free) begin
          emit_valid            = 1'b1;
          emit_word.out_byte    = lit;
          emit_word.last_of_run = 1'b1;
          win_req.we            = 1'b1;
          win_req.waddr         = wp;
          win_req.wdata         = lit;
          wp_next               = wp + WIN_AW'(1);
          state_next            = ST_IDLE;
        end
      end

      ST_READ: begin
        win_req.re    = 1'b1;
        win_req.raddr = raddr;
        raddr_next    = raddr + WIN_AW'(1);
        state_next    = ST_WRITE;
      end

      ST_WRITE: begin
        // copied byte goes out and back into the window
        if (slot_free) begin
          emit_valid            = 1'b1;
          emit_word.out_byte    = win_rdata;
          emit_word.last_of_run = (rem == '0);
          win_req.we            = 1'b1;
          win_req.waddr         = wp;
          win_req.wdata         = win_rdata;
          wp_next               = wp + WIN_AW'(1);
          rem_next              = rem - RUN_W'(1);
          state_next            = (rem == '0) ? ST_IDLE : ST_READ;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/lzss_window_decompressor.sv */
// Channel | Direction | Handshake            | Word
// src     | in        | src_valid/src_ready  | code_byte, stream_start
// dst     | out       | dst_valid/dst_ready  | out_byte, last_of_run
//
// Flag word or first match word: taken in ST_IDLE. Literal: emitted from ST_LIT.
// Match: 3 to 18 copied bytes, each read in ST_READ and then emitted and
// written back in ST_WRITE, a read-then-write loop through the window port.
// Reset is synchronous; the window reads as spaces/zeros until written.
// A stalled dst holds the sequencer; src_ready is low while a word is busy.
`default_nettype none
module lzss_window_decompressor (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  src_valid,
  output logic                       src_ready,
  input  wire lzsswd_pkg::src_word_t src_word,
  output logic                       dst_valid,
  input  wire logic                  dst_ready,
  output lzsswd_pkg::dst_word_t      dst_word
);
  import lzsswd_pkg::*;

  logic       slot_free;
  logic       emit_valid;
  dst_word_t  emit_word;
  win_req_t   win_req;
  logic [7:0] win_rdata;

  assign slot_free = !dst_valid || dst_ready;

  lzsswd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src_word   (src_word),
    .slot_free  (slot_free),
    .emit_valid (emit_valid),
    .emit_word  (emit_word),
    .win_req    (win_req),
    .win_rdata  (win_rdata)
  );

  lzsswd_window u_window (
    .clk   (clk),
    .rst   (rst),
    .req   (win_req),
    .rdata (win_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (emit_valid) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      dst_word <= emit_word;
    end
  end

endmodule
`default_nettype wire

/* hdl/lzsswd_checker.sv */
`default_nettype none
`include "lzss_window_decompressor_defines.svh"
module lzsswd_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  src_valid,
  input wire logic                  src_ready,
  input wire lzsswd_pkg::src_word_t src_word,
  input wire logic                  dst_valid,
  input wire logic                  dst_ready,
  input wire lzsswd_pkg::dst_word_t dst_word
);
  import lzsswd_pkg::*;

  // stalled output word holds
  `LZSSWD_ASSERT_NEXT(a_dst_hold, dst_valid && !dst_ready, dst_valid && $stable(dst_word), "dst word changed while stalled")

  // mid-run the decoder takes no new input
  `LZSSWD_ASSERT_NOW(a_run_busy, dst_valid && !dst_word.last_of_run, !src_ready, "input taken during a copy run")

  // a stream start word yields no output
  `LZSSWD_ASSERT_NEXT(a_start_silent, src_valid && src_ready && src_word.stream_start && !dst_valid, !dst_valid, "output after stream start word")

endmodule

bind lzss_window_decompressor lzsswd_checker u_lzsswd_checker (.*);
`default_nettype wire

/* tb/lzss_window_decompressor_checker.sv */
`timescale 1ns / 1ps
// Watches both channels, decodes the accepted code words in step with the
// block and compares every output word with the oldest predicted byte.
module lzss_window_decompressor_checker (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  src_valid,
  input  wire logic                  src_ready,
  input  wire lzsswd_pkg::src_word_t src_word,
  input  wire logic                  dst_valid,
  input  wire logic                  dst_ready,
  input  wire lzsswd_pkg::dst_word_t dst_word,
  output int                         errors,
  output int                         pending
);
  import lzsswd_pkg::*;

  // Decoder state
  logic [7:0]        hist_win [WIN_DEPTH];
  logic [WIN_AW-1:0] wr_ptr;
  logic [8:0]        flag_bits;   // remaining flags under a marker bit
  logic              match_open;  // first byte of a match token is held
  logic [7:0]        pos_low;

  dst_word_t decoded_bytes[$];

  // New stream: refill the low window with spaces, keep the top part
  function automatic void restart_stream();
    for (int i = 0; i < FILL_LIMIT; i++) begin
      hist_win[i] = FILL_BYTE;
    end
    wr_ptr     = WP_START;
    flag_bits  = '0;
    match_open = 1'b0;
    pos_low    = '0;
  endfunction

  // One decoded byte goes out and into the window
  function automatic void emit_byte(logic [7:0] b, logic last);
    decoded_bytes.push_back('{out_byte: b, last_of_run: last});
    hist_win[wr_ptr] = b;
    wr_ptr++;
  endfunction

  function automatic void decode_code_byte(src_word_t w);
    logic [WIN_AW-1:0] rd_pos;
    int                run_len;
    if (w.stream_start) begin
      restart_stream();
    end
    if (flag_bits <= 9'd1) begin
      flag_bits = {1'b1, w.code_byte};
    end else if (match_open) begin
      // high nibble lands above bit 7, so only the held byte's low bits count
      rd_pos  = pos_low[WIN_AW-1:0];
      run_len = int'(w.code_byte[3:0]) + MIN_MATCH_OFFSET + 1;
      for (int k = 0; k < run_len; k++) begin
        emit_byte(hist_win[rd_pos], k == run_len - 1);
        rd_pos++;
      end
      match_open = 1'b0;
      pos_low    = '0;
      flag_bits  = flag_bits >> 1;
    end else if (flag_bits[0]) begin
      emit_byte(w.code_byte, 1'b1);
      flag_bits = flag_bits >> 1;
    end else begin
      pos_low    = w.code_byte;
      match_open = 1'b1;
    end
  endfunction

  // Predict on input words, compare on output words
  always @(posedge clk) begin
    dst_word_t exp_w;
    if (rst) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        hist_win[i] = 8'h00;
      end
      restart_stream();
      decoded_bytes.delete();
      errors = 0;
    end else begin
      if (src_valid && src_ready) begin
        decode_code_byte(src_word);
      end
      if (dst_valid && dst_ready) begin
        if (decoded_bytes.size() == 0) begin
          $display("%0t: unexpected word, expected none, got out_byte %02h last_of_run %0b",
                   $time, dst_word.out_byte, dst_word.last_of_run);
          errors++;
        end else begin
          exp_w = decoded_bytes.pop_front();
          if (dst_word.out_byte !== exp_w.out_byte) begin
            $display("%0t: out_byte expected %02h got %02h",
                     $time, exp_w.out_byte, dst_word.out_byte);
            errors++;
          end
          if (dst_word.last_of_run !== exp_w.last_of_run) begin
            $display("%0t: last_of_run expected %0b got %0b",
                     $time, exp_w.last_of_run, dst_word.last_of_run);
            errors++;
          end
        end
      end
    end
    pending = decoded_bytes.size();
  end

endmodule

/* tb/lzss_window_decompressor_tb.sv */
`timescale 1ns / 1ps
module lzss_window_decompressor_tb;
  import lzsswd_pkg::*;

  localparam int RANDOM_WORDS = 480;
  localparam int STALL_LIMIT  = 1000;

  logic      clk;
  logic      rst;
  logic      src_valid;
  logic      src_ready;
  src_word_t src_word;
  logic      dst_valid;
  logic      dst_ready;
  dst_word_t dst_word;

  int errors;
  int pending;
  int words_sent;
  int idle_cycles;
  bit quiet;               // no idling on either side while set
  logic [WIN_AW-1:0] stim_wp;  // rough write pointer, to aim matches

  lzss_window_decompressor dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_word  (src_word),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_word  (dst_word)
  );

  lzss_window_decompressor_checker chk (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_word  (src_word),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_word  (dst_word),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Receiver stalls
  always @(negedge clk) begin
    dst_ready <= quiet || ($urandom_range(0, 99) >= 31);
  end

  // Watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (src_valid && src_ready) || (dst_valid && dst_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_word(logic [7:0] b, logic start);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 31) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_word  <= '{code_byte: b, stream_start: start};
    do @(posedge clk); while (!(src_valid && src_ready));
    words_sent++;
  endtask

  // Well-formed stream; with cut set, the last match token loses its second byte
  task automatic send_stream(int n_tok, bit cut);
    logic [7:0]        flags;
    logic [7:0]        first_b;
    logic [7:0]        second_b;
    logic [WIN_AW-1:0] pos;
    stim_wp = WP_START;
    flags   = '0;
    for (int t = 0; t < n_tok; t++) begin
      if (t % 8 == 0) begin
        flags = 8'($urandom);
        if (cut && n_tok - 1 < t + 8) begin
          flags[(n_tok - 1) % 8] = 1'b0;
        end
        send_word(flags, t == 0);
      end
      if (flags[t % 8]) begin
        send_word(8'($urandom), 1'b0);
        stim_wp++;
      end else begin
        case ($urandom_range(0, 3))
          0: pos = stim_wp - WIN_AW'(1 + $urandom_range(0, 3));  // overlapping copy
          1: pos = WIN_AW'(FILL_LIMIT + $urandom_range(0, 15));  // upper window area
          default: pos = WIN_AW'($urandom_range(0, WIN_DEPTH - 1));
        endcase
        first_b       = 8'($urandom);
        first_b[6:0]  = pos;
        second_b      = 8'($urandom);
        send_word(first_b, 1'b0);
        if (!(cut && t == n_tok - 1)) begin
          send_word(second_b, 1'b0);
          stim_wp += WIN_AW'(int'(second_b[3:0]) + MIN_MATCH_OFFSET + 1);
        end
      end
    end
  endtask

  initial begin
    int pick;
    rst        = 1'b1;
    src_valid  = 1'b0;
    src_word   = '0;
    quiet      = 1'b0;
    words_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: four matches then four literals
    send_word(8'hF0, 1'b1);
    send_word(8'hF8, 1'b0);  // zeros from the upper area, shortest run
    send_word(8'hF0, 1'b0);
    send_word(8'h00, 1'b0);  // spaces, longest run, pointer wraps
    send_word(8'h0F, 1'b0);
    send_word(8'h04, 1'b0);  // copy overlaps its own output
    send_word(8'h35, 1'b0);
    send_word(8'h8A, 1'b0);
    send_word(8'hC7, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(8'h5A, 1'b0);
    // Flag word with no tokens after it, dropped by the next stream
    send_word(8'h02, 1'b0);
    // New stream reads the kept upper area
    send_word(8'hFE, 1'b1);
    send_word(8'h70, 1'b0);
    send_word(8'h04, 1'b0);
    send_word(8'h7E, 1'b0);

    // Random: mostly well-formed streams, some cut short, some noise
    while (words_sent < RANDOM_WORDS + 18) begin
      quiet = (words_sent >= 150 && words_sent < 300);
      pick  = $urandom_range(0, 99);
      if (pick < 80) begin
        send_stream($urandom_range(1, 20), 1'b0);
      end else if (pick < 88) begin
        send_stream($urandom_range(1, 12), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_word(8'($urandom), $urandom_range(0, 7) == 0);
        end
      end
    end
    quiet = 1'b0;
    @(negedge clk);
    src_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/lzsswd_pkg.sv
hdl/lzsswd_window.sv
hdl/lzsswd_ctrl.sv
hdl/lzss_window_decompressor.sv
hdl/lzsswd_checker.sv
tb/lzss_window_decompressor_checker.sv
tb/lzss_window_decompressor_tb.sv
